FILE: rtl/se2_edge_residual_jacobian_macros.svh
// assertion helpers
`ifndef SE2_EDGE_RESIDUAL_JACOBIAN_MACROS_SVH
`define SE2_EDGE_RESIDUAL_JACOBIAN_MACROS_SVH

// same-cycle implication
`define SE2_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SE2_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/se2_pkg.sv
package se2_pkg;

    localparam int CW    = 34;
    localparam int DW    = 33;
    localparam int HW    = 35;
    localparam int RW    = 36;
    localparam int AW    = 37;
    localparam int NSTEP = 30;
    localparam int SW    = 5;
    localparam int NV    = NSTEP + 6;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic signed [HW-1:0] PI_Q29      = 35'sd1686629713;
    localparam logic signed [HW-1:0] HALF_PI_Q29 = 35'sd843314856;
    localparam logic signed [HW-1:0] TWO_PI_Q29  = 35'sd3373259426;

    localparam logic [31:0] ATAN_TAB [NSTEP] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
    };

    typedef enum logic [1:0] {
        REG_ODOM_POS,
        REG_ODOM_ROT,
        REG_LOOP_POS,
        REG_LOOP_ROT
    } reg_idx_t;

    typedef enum logic [1:0] {
        SH_16,
        SH_29,
        SH_30
    } shift_sel_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } cordic_t;

    typedef struct packed {
        logic                 kind;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [31:0]   mdx;
        logic signed [31:0]   mdy;
        logic signed [HW-1:0] dth;
    } side_t;

endpackage

FILE: rtl/se2_cordic_step.sv
module se2_cordic_step (
    input  logic                clk,
    input  logic                en,
    input  logic [se2_pkg::SW-1:0] step,
    input  se2_pkg::cordic_t    d_in,
    input  se2_pkg::side_t      s_in,
    output se2_pkg::cordic_t    d_out,
    output se2_pkg::side_t      s_out
);
    import se2_pkg::*;

    cordic_t d_reg;
    cordic_t d_next;
    side_t   s_reg;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] ang;

    always_comb
    begin
        xs  = d_in.x >>> step;
        ys  = d_in.y >>> step;
        ang = CW'(ATAN_TAB[step]);
        d_next.flip = d_in.flip;
        if (d_in.z >= 0)
        begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.z = d_in.z - ang;
        end
        else
        begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.z = d_in.z + ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
            s_reg <= s_in;
        end
    end

    assign d_out = d_reg;
    assign s_out = s_reg;

endmodule

FILE: rtl/se2_wmul.sv
module se2_wmul (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [se2_pkg::AW-1:0] a,
    input  logic [31:0]                w,
    input  se2_pkg::shift_sel_t        shc,
    output logic signed [31:0]         res
);
    import se2_pkg::*;

    logic signed [16:0] wh;
    logic signed [16:0] wl;
    logic signed [AW+16:0] ph_next;
    logic signed [AW+16:0] ph_reg;
    logic signed [AW+17:0] pl_next;
    logic signed [AW+17:0] pl_reg;
    logic signed [AW+17:0] half;
    shift_sel_t shc_reg;
    logic signed [AW+18:0] sum;
    logic signed [AW+18:0] shifted;
    logic signed [31:0] res_next;
    logic signed [31:0] res_reg;

    always_comb
    begin
        wh = $signed({1'b0, w[31:16]});
        wl = $signed({1'b0, w[15:0]});
        case (shc)
            SH_16:   half = (AW+18)'(1) <<< 15;
            SH_29:   half = (AW+18)'(1) <<< 28;
            SH_30:   half = (AW+18)'(1) <<< 29;
            default: half = (AW+18)'(1) <<< 15;
        endcase
        ph_next = a * wh;
        pl_next = a * wl + half;
    end

    always_comb
    begin
        sum = (AW+19)'(ph_reg) + (AW+19)'(pl_reg >>> 16);
        case (shc_reg)
            SH_16:   shifted = sum;
            SH_29:   shifted = sum >>> 13;
            SH_30:   shifted = sum >>> 14;
            default: shifted = sum;
        endcase
        if (shifted > (AW+19)'(64'sd2147483647))
            res_next = 32'sh7FFFFFFF;
        else if (shifted < -(AW+19)'(64'sd2147483648))
            res_next = 32'sh80000000;
        else
            res_next = shifted[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg  <= ph_next;
            pl_reg  <= pl_next;
            shc_reg <= shc;
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: rtl/se2_edge_residual_jacobian.sv
// throughput: one request per cycle while the output is not stalled, set by the 30-stage unrolled cordic pipeline
// a stalled output freezes every stage, nothing is lost or repeated
// reset: async active low, clears valid bits, weights return to 1.0 (0x00010000)
module se2_edge_residual_jacobian (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               edge_kind,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_heading,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic signed [31:0] second_heading,
    input  logic signed [31:0] meas_dx,
    input  logic signed [31:0] meas_dy,
    input  logic signed [31:0] meas_dheading,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic signed [31:0] res_heading,
    output logic signed [31:0] jac_cos,
    output logic signed [31:0] jac_sin,
    output logic signed [31:0] jac_turn_x,
    output logic signed [31:0] jac_turn_y
);
    import se2_pkg::*;

    `include "se2_edge_residual_jacobian_macros.svh"

    logic [31:0] odom_pos_reg;
    logic [31:0] odom_rot_reg;
    logic [31:0] loop_pos_reg;
    logic [31:0] loop_rot_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    logic [NV-1:0] vld_reg;
    logic          en;

    cordic_t c_stage [NSTEP+1];
    side_t   s_stage [NSTEP+1];
    cordic_t c0_next;
    side_t   s0_next;
    cordic_t c0_reg;
    side_t   s0_reg;
    logic signed [HW-1:0] ang;
    logic signed [HW-1:0] dth;

    logic signed [CW-1:0] cos_reg;
    logic signed [CW-1:0] sin_reg;
    side_t                side31_next;
    side_t                side31_reg;

    logic signed [CW+DW-1:0] cdx_reg;
    logic signed [CW+DW-1:0] sdy_reg;
    logic signed [CW+DW-1:0] cdy_reg;
    logic signed [CW+DW-1:0] sdx_reg;
    logic signed [CW-1:0]    cos32_reg;
    logic signed [CW-1:0]    sin32_reg;
    side_t                   side32_reg;
    logic signed [HW-1:0]    dth_wrap;

    logic signed [CW+DW:0]   sum_x;
    logic signed [CW+DW:0]   sum_y;
    logic signed [RW-1:0]    rx_reg;
    logic signed [RW-1:0]    ry_reg;
    logic signed [CW-1:0]    cos33_reg;
    logic signed [CW-1:0]    sin33_reg;
    logic signed [31:0]      mdx33_reg;
    logic signed [31:0]      mdy33_reg;
    logic signed [HW-1:0]    dth33_reg;
    logic [31:0]             wpos_reg;
    logic [31:0]             wrot_reg;

    // config port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_ODOM_POS: prdata = odom_pos_reg;
            REG_ODOM_ROT: prdata = odom_rot_reg;
            REG_LOOP_POS: prdata = loop_pos_reg;
            REG_LOOP_ROT: prdata = loop_rot_reg;
            default:      prdata = odom_pos_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odom_pos_reg <= 32'h0001_0000;
            odom_rot_reg <= 32'h0001_0000;
            loop_pos_reg <= 32'h0001_0000;
            loop_rot_reg <= 32'h0001_0000;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ODOM_POS: odom_pos_reg <= pwdata;
                REG_ODOM_ROT: odom_rot_reg <= pwdata;
                REG_LOOP_POS: loop_pos_reg <= pwdata;
                REG_LOOP_ROT: loop_rot_reg <= pwdata;
                default:      odom_pos_reg <= odom_pos_reg;
            endcase
        end
    end

    // pipeline control
    assign en        = !vld_reg[NV-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NV-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NV-2:0], in_valid};
    end

    // stage 0: fold heading, deltas, raw heading difference
    always_comb
    begin
        ang          = HW'(first_heading);
        c0_next.flip = 1'b0;
        if (ang > HALF_PI_Q29)
        begin
            ang          = ang - PI_Q29;
            c0_next.flip = 1'b1;
        end
        else if (ang < -HALF_PI_Q29)
        begin
            ang          = ang + PI_Q29;
            c0_next.flip = 1'b1;
        end
        c0_next.x = CORDIC_GAIN;
        c0_next.y = '0;
        c0_next.z = CW'(ang <<< 1);

        dth = HW'(second_heading) - HW'(first_heading) - HW'(meas_dheading);

        s0_next.kind = edge_kind;
        s0_next.dx   = DW'(second_x) - DW'(first_x);
        s0_next.dy   = DW'(second_y) - DW'(first_y);
        s0_next.mdx  = meas_dx;
        s0_next.mdy  = meas_dy;
        s0_next.dth  = dth;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg <= c0_next;
            s0_reg <= s0_next;
        end
    end

    assign c_stage[0] = c0_reg;
    assign s_stage[0] = s0_reg;

    // cordic stages
    for (genvar i = 0; i < NSTEP; i++)
    begin : g_cordic
        se2_cordic_step u_step (
            .clk   (clk),
            .en    (en),
            .step  (SW'(i)),
            .d_in  (c_stage[i]),
            .s_in  (s_stage[i]),
            .d_out (c_stage[i+1]),
            .s_out (s_stage[i+1])
        );
    end

    // heading wrap, one step of 2*pi in each of two stages
    always_comb
    begin
        side31_next = s_stage[NSTEP];
        if (s_stage[NSTEP].dth > PI_Q29)
            side31_next.dth = s_stage[NSTEP].dth - TWO_PI_Q29;
        else if (s_stage[NSTEP].dth <= -PI_Q29)
            side31_next.dth = s_stage[NSTEP].dth + TWO_PI_Q29;

        dth_wrap = side32_reg.dth;
        if (side32_reg.dth > PI_Q29)
            dth_wrap = side32_reg.dth - TWO_PI_Q29;
        else if (side32_reg.dth <= -PI_Q29)
            dth_wrap = side32_reg.dth + TWO_PI_Q29;
    end

    // unfold, products, rotation, weight select
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg    <= c_stage[NSTEP].flip ? -c_stage[NSTEP].x : c_stage[NSTEP].x;
            sin_reg    <= c_stage[NSTEP].flip ? -c_stage[NSTEP].y : c_stage[NSTEP].y;
            side31_reg <= side31_next;

            cdx_reg    <= cos_reg * side31_reg.dx;
            sdy_reg    <= sin_reg * side31_reg.dy;
            cdy_reg    <= cos_reg * side31_reg.dy;
            sdx_reg    <= sin_reg * side31_reg.dx;
            cos32_reg  <= cos_reg;
            sin32_reg  <= sin_reg;
            side32_reg <= side31_reg;

            rx_reg     <= RW'(sum_x >>> 30);
            ry_reg     <= RW'(sum_y >>> 30);
            cos33_reg  <= cos32_reg;
            sin33_reg  <= sin32_reg;
            mdx33_reg  <= side32_reg.mdx;
            mdy33_reg  <= side32_reg.mdy;
            dth33_reg  <= dth_wrap;
            wpos_reg   <= side32_reg.kind ? loop_pos_reg : odom_pos_reg;
            wrot_reg   <= side32_reg.kind ? loop_rot_reg : odom_rot_reg;
        end
    end

    assign sum_x = (CW+DW+1)'(cdx_reg) + (CW+DW+1)'(sdy_reg) + ((CW+DW+1)'(1) <<< 29);
    assign sum_y = (CW+DW+1)'(cdy_reg) - (CW+DW+1)'(sdx_reg) + ((CW+DW+1)'(1) <<< 29);

    // weighted outputs
    se2_wmul u_res_x (
        .clk (clk), .en (en), .a (AW'(rx_reg) - AW'(mdx33_reg)),
        .w (wpos_reg), .shc (SH_16), .res (res_x)
    );
    se2_wmul u_res_y (
        .clk (clk), .en (en), .a (AW'(ry_reg) - AW'(mdy33_reg)),
        .w (wpos_reg), .shc (SH_16), .res (res_y)
    );
    se2_wmul u_res_h (
        .clk (clk), .en (en), .a (AW'(dth33_reg)),
        .w (wrot_reg), .shc (SH_29), .res (res_heading)
    );
    se2_wmul u_jac_c (
        .clk (clk), .en (en), .a (AW'(cos33_reg)),
        .w (wpos_reg), .shc (SH_30), .res (jac_cos)
    );
    se2_wmul u_jac_s (
        .clk (clk), .en (en), .a (AW'(sin33_reg)),
        .w (wpos_reg), .shc (SH_30), .res (jac_sin)
    );
    se2_wmul u_jac_tx (
        .clk (clk), .en (en), .a (AW'(ry_reg)),
        .w (wpos_reg), .shc (SH_16), .res (jac_turn_x)
    );
    se2_wmul u_jac_ty (
        .clk (clk), .en (en), .a (-AW'(rx_reg)),
        .w (wpos_reg), .shc (SH_16), .res (jac_turn_y)
    );

    `SE2_ASSERT_NXT(a_stall_freeze, vld_reg[NV-1] && !out_ready, $stable(vld_reg), "pipeline moved during stall")
    `SE2_ASSERT_NXT(a_accept_enters, in_valid && in_ready, vld_reg[0], "accepted request not in first stage")
    `SE2_ASSERT_NXT(a_cfg_write, psel && penable && pwrite && (paddr[3:2] == REG_LOOP_ROT), loop_rot_reg == $past(pwdata), "loop rot weight write lost")

endmodule

FILE: verif/se2_edge_checker.sv
`timescale 1ns / 100ps
module se2_edge_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               edge_kind,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_heading,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic signed [31:0] second_heading,
    input  logic signed [31:0] meas_dx,
    input  logic signed [31:0] meas_dy,
    input  logic signed [31:0] meas_dheading,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] res_x,
    input  logic signed [31:0] res_y,
    input  logic signed [31:0] res_heading,
    input  logic signed [31:0] jac_cos,
    input  logic signed [31:0] jac_sin,
    input  logic signed [31:0] jac_turn_x,
    input  logic signed [31:0] jac_turn_y,
    output int                 fail_count,
    output int                 pending
);
    import se2_pkg::*;

    typedef struct {
        logic signed [31:0] f [7];
    } edge_result_t;

    logic [31:0] weight [4];
    edge_result_t expected_q [$];

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint weigh(longint a, logic [31:0] w, int sh);
        longint ph;
        longint pl;
        ph = a * longint'({16'd0, w[31:16]});
        pl = a * longint'({16'd0, w[15:0]}) + (longint'(1) << (sh - 1));
        return floor_shift(ph + floor_shift(pl, 16), sh - 16);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic rotate_heading(input longint th, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint xs;
        bit flip;
        x = 64'h26DD3B6A;
        y = 0;
        flip = 0;
        if (th > 64'sd843314856)
        begin
            th -= 64'sd1686629713;
            flip = 1;
        end
        else if (th < -64'sd843314856)
        begin
            th += 64'sd1686629713;
            flip = 1;
        end
        z = th * 2;
        for (int i = 0; i < 30; i++)
        begin
            xs = x >>> i;
            if (z >= 0)
            begin
                x -= y >>> i;
                y += xs;
                z -= longint'(ATAN_TAB[i]);
            end
            else
            begin
                x += y >>> i;
                y -= xs;
                z += longint'(ATAN_TAB[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_edge();
        edge_result_t r;
        logic [31:0] wp;
        logic [31:0] wr;
        longint c;
        longint s;
        longint dx;
        longint dy;
        longint rx;
        longint ry;
        longint dth;
        wp = edge_kind ? weight[REG_LOOP_POS] : weight[REG_ODOM_POS];
        wr = edge_kind ? weight[REG_LOOP_ROT] : weight[REG_ODOM_ROT];
        rotate_heading(longint'(first_heading), c, s);
        dx = longint'(second_x) - longint'(first_x);
        dy = longint'(second_y) - longint'(first_y);
        rx = floor_shift(c * dx + s * dy + (longint'(1) << 29), 30);
        ry = floor_shift(c * dy - s * dx + (longint'(1) << 29), 30);
        dth = longint'(second_heading) - longint'(first_heading) - longint'(meas_dheading);
        while (dth > 64'sd1686629713)
            dth -= 64'sd3373259426;
        while (dth <= -64'sd1686629713)
            dth += 64'sd3373259426;
        r.f[0] = clamp32(weigh(rx - longint'(meas_dx), wp, 16));
        r.f[1] = clamp32(weigh(ry - longint'(meas_dy), wp, 16));
        r.f[2] = clamp32(weigh(dth, wr, 29));
        r.f[3] = clamp32(weigh(c, wp, 30));
        r.f[4] = clamp32(weigh(s, wp, 30));
        r.f[5] = clamp32(weigh(ry, wp, 16));
        r.f[6] = clamp32(weigh(-rx, wp, 16));
        expected_q = {expected_q, r};
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("error: %s got %h expected %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        edge_result_t e;
        logic signed [31:0] got [7];
        if (!rst_n)
        begin
            fail_count = 0;
            for (int i = 0; i < 4; i++)
                weight[i] = 32'h00010000;
            expected_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
                weight[paddr[3:2]] = pwdata;
            if (in_valid && in_ready)
                predict_edge();
            if (out_valid && out_ready)
            begin
                got = '{res_x, res_y, res_heading, jac_cos, jac_sin, jac_turn_x, jac_turn_y};
                if (expected_q.size() == 0)
                    report("unexpected result", got[0], 0);
                else
                begin
                    e = expected_q.pop_front();
                    for (int k = 0; k < 7; k++)
                        if (got[k] !== e.f[k])
                            report($sformatf("field %0d", k), got[k], e.f[k]);
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import se2_pkg::*;

    localparam int WATCHDOG = 20000;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 0;
    logic in_ready;
    logic edge_kind = 0;
    logic signed [31:0] first_x = 0, first_y = 0, first_heading = 0;
    logic signed [31:0] second_x = 0, second_y = 0, second_heading = 0;
    logic signed [31:0] meas_dx = 0, meas_dy = 0, meas_dheading = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [31:0] res_x, res_y, res_heading, jac_cos, jac_sin, jac_turn_x, jac_turn_y;
    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit hold_off = 0;

    always #4 clk = ~clk;

    se2_edge_residual_jacobian u_top (.*);
    se2_edge_checker u_chk (.*);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("se2_edge_residual_jacobian: mismatch");
            $finish;
        end
    end

    // receiver stall pattern
    initial
    begin
        int mode;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 0;
            else
            begin
                mode = ($urandom_range(0, 199) < 3) ? 0 : 1;
                if (mode == 0)
                begin
                    out_ready <= 0;
                    repeat ($urandom_range(5, 40)) @(negedge clk);
                end
                else
                    out_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hffffffff;
            2: return 32'h00010000;
            3: return $urandom_range(0, 32'h0004ffff);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_field(input bit heading);
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            3: return 0;
            default: return heading ? $urandom : {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
        endcase
    endfunction

    task automatic send_edge(input logic k, input logic [31:0] v [9]);
        in_valid <= 1;
        edge_kind <= k;
        first_x <= v[0];
        first_y <= v[1];
        first_heading <= v[2];
        second_x <= v[3];
        second_y <= v[4];
        second_heading <= v[5];
        meas_dx <= v[6];
        meas_dy <= v[7];
        meas_dheading <= v[8];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int n);
        logic [31:0] v [9];
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && n > 0)
            begin
                for (int i = 0; i < 9; i++)
                    v[i] = rand_field(i == 2 || i == 5 || i == 8);
                send_edge(1'($urandom_range(0, 1)), v);
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        in_valid <= 0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] v [9];
        logic [31:0] hd [8];
        repeat (3) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: extremes of headings and positions
        hd = '{32'h0, 32'h7fffffff, 32'h80000000, 32'd843314856, 32'd843314857,
               -32'sd843314857, 32'd1686629713, -32'sd1686629713};
        for (int j = 0; j < 8; j++)
        begin
            v = '{32'h0, 32'h0, hd[j], 32'h00010000, 32'h00020000, hd[7 - j],
                  32'h0, 32'h0, hd[j]};
            send_edge(j[0], v);
        end
        v = '{32'h80000000, 32'h80000000, 32'h0, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000};
        send_edge(0, v);
        v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        send_edge(1, v);
        v = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff};
        send_edge(1, v);
        in_valid <= 0;
        drain();

        write_reg(REG_ODOM_POS, 32'hffffffff);
        write_reg(REG_ODOM_ROT, 32'hffffffff);
        write_reg(REG_LOOP_POS, 32'h0);
        write_reg(REG_LOOP_ROT, 32'h0);
        send_random(150);

        // long receiver hold-off while the sender keeps offering
        hold_off = 1;
        fork
            send_random(120);
            repeat (300) @(negedge clk);
        join_any
        hold_off = 0;
        wait fork;
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_ODOM_POS, rand_weight());
            write_reg(REG_ODOM_ROT, rand_weight());
            write_reg(REG_LOOP_POS, rand_weight());
            write_reg(REG_LOOP_ROT, rand_weight());
            send_random(250);
            drain();
        end

        if (fail_count == 0)
            $display("se2_edge_residual_jacobian: match");
        else
            $display("se2_edge_residual_jacobian: mismatch");
        $finish;
    end

endmodule
